[rtl/preroll_postroll_audio_capture_top_defines.svh]
// Assertion macros for the pre-roll/post-roll audio capture block
`ifndef PREROLL_POSTROLL_AUDIO_CAPTURE_TOP_DEFINES_SVH
`define PREROLL_POSTROLL_AUDIO_CAPTURE_TOP_DEFINES_SVH

// same-cycle implication, reset masked
`define PPAC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define PPAC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ppac_pkg.sv]
// Types and constants shared by the audio capture block
package ppac_pkg;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_BEGIN  = 2'd1,
		OP_COMMIT = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PREROLL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POSTROLL = 2'd2;

	typedef struct packed {
		op_t                opcode;
		logic signed [15:0] sample_in;
		logic [15:0]        read_index;
	} ppac_req_t;

	typedef struct packed {
		logic signed [15:0] read_sample;
		logic               read_valid;
		logic [16:0]        capture_length;
		logic               recording;
		logic               post_pending;
	} ppac_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_RESP
	} state_t;

endpackage

[rtl/ppac_ram.sv]
// Generic single-write, single-read RAM with registered read data
module ppac_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/preroll_postroll_audio_capture_top.sv]
// Top level of the pre-roll/post-roll audio capture block
//
// One request is taken when start is high and busy is low; busy then stays high
// until the result has been shown. Every request gives one result, held on rsp
// for exactly one cycle with done high; there is no back-pressure, so the result
// must be taken in that cycle. A sample, commit or read request passes from the
// EXEC state to the RESP state, where its result is shown; the block is then free
// again. A begin also copies min(ring fill, maximum length) pre-roll ring entries
// into the capture store, each read in COPY_RD through the ring RAM's registered
// read port and written in COPY_WR, before its result is shown. Both stores are
// RAMs that come up undefined; no clearing pass is run after reset.
module preroll_postroll_audio_capture_top #(
	parameter int RING_DEPTH    = 8192,
	parameter int CAPTURE_DEPTH = 65536
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  ppac_pkg::ppac_req_t                  req,
	input  logic                                 cfg_we,
	input  logic [ppac_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [ppac_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                 done,
	output ppac_pkg::ppac_rsp_t                  rsp
);

	import ppac_pkg::*;

	localparam int RAW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int RFW  = $clog2(RING_DEPTH + 1);
	localparam int CAW  = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;
	localparam int CW   = ($clog2(CAPTURE_DEPTH + 1) > 17) ? $clog2(CAPTURE_DEPTH + 1) : 17;
	localparam int TW   = CW + 1;
	localparam int IXW  = (CAW > 16) ? CAW : 16;
	localparam int CMPW = (IXW > CW) ? IXW : CW;
	localparam logic [CW-1:0] LIM_RST = (CAPTURE_DEPTH < 65536) ?
		CW'(CAPTURE_DEPTH) : CW'(65536);

	state_t state_q, state_d;

	op_t                op_q;
	logic signed [15:0] sample_q;
	logic [15:0]        idx_q;

	logic [CW-1:0]  lim_q;
	logic [RFW-1:0] rlen_q;
	logic [16:0]    postroll_q;

	logic [RAW-1:0] wpos_q;
	logic [RFW-1:0] fill_q;
	logic [RAW-1:0] rp_q;
	logic [CW-1:0]  count_q;
	logic           active_q;
	logic           commit_q;
	logic [TW-1:0]  target_q;
	logic           rd_ok_q;

	logic           accept;
	logic [RAW-1:0] wpos_nxt;
	logic [RAW-1:0] rp_nxt;
	logic           appending;
	logic [CW-1:0]  count_new;
	logic           stop_on_sample;
	logic           copy_more;
	logic [RAW-1:0] copy_start;
	logic           rd_in_range;

	logic           ring_we;
	logic [15:0]    ring_rdata;
	logic           cap_we;
	logic [CAW-1:0] cap_waddr;
	logic [15:0]    cap_wdata;
	logic [CAW-1:0] cap_raddr;
	logic [15:0]    cap_rdata;
	logic [IXW-1:0] idx_ext;
	logic [CW-1:0]  cfg_lim;
	logic [RFW-1:0] cfg_rlen;

	assign accept = start && !busy;

	// ring pointer steps, wrapping at the ring length
	assign wpos_nxt = ((RFW'(wpos_q) + RFW'(1)) == rlen_q) ? '0 : wpos_q + RAW'(1);
	assign rp_nxt   = ((RFW'(rp_q) + RFW'(1)) == rlen_q) ? '0 : rp_q + RAW'(1);
	assign copy_start = ((fill_q == rlen_q) && (rlen_q != '0)) ? wpos_q : '0;

	assign appending = active_q && (count_q < lim_q);
	assign count_new = appending ? count_q + CW'(1) : count_q;
	assign stop_on_sample = (count_new >= lim_q) ||
		(commit_q && (TW'(count_new) >= target_q));

	assign copy_more = (count_q < CW'(fill_q)) && (count_q < lim_q);

	assign idx_ext     = IXW'(idx_q);
	assign rd_in_range = CMPW'(idx_q) < CMPW'(count_q);

	// clamp configuration values
	always_comb begin
		if ((cfg_data == '0) || (32'(cfg_data) > 32'(CAPTURE_DEPTH))) begin
			cfg_lim = CW'(CAPTURE_DEPTH);
		end else begin
			cfg_lim = CW'(cfg_data);
		end
		if (32'(cfg_data[13:0]) > 32'(RING_DEPTH)) begin
			cfg_rlen = RFW'(RING_DEPTH);
		end else begin
			cfg_rlen = RFW'(cfg_data[13:0]);
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = (state_q != ST_IDLE);
		done      = 1'b0;
		ring_we   = 1'b0;
		cap_we    = 1'b0;
		cap_waddr = count_q[CAW-1:0];
		cap_wdata = sample_q;
		cap_raddr = idx_ext[CAW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (op_q)
					OP_SAMPLE: begin
						ring_we = (rlen_q != '0);
						cap_we  = appending;
						state_d = ST_RESP;
					end
					OP_BEGIN: state_d = ST_COPY_RD;
					default:  state_d = ST_RESP;
				endcase
			end
			ST_COPY_RD: begin
				state_d = copy_more ? ST_COPY_WR : ST_RESP;
			end
			ST_COPY_WR: begin
				cap_we    = 1'b1;
				cap_wdata = ring_rdata;
				state_d   = ST_COPY_RD;
			end
			ST_RESP: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the request
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= req.opcode;
			sample_q <= req.sample_in;
			idx_q    <= req.read_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q      <= LIM_RST;
			rlen_q     <= '0;
			postroll_q <= '0;
			wpos_q     <= '0;
			fill_q     <= '0;
			rp_q       <= '0;
			count_q    <= '0;
			active_q   <= 1'b0;
			commit_q   <= 1'b0;
			target_q   <= '0;
			rd_ok_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MAX_LEN:  lim_q <= cfg_lim;
				REG_PREROLL: begin
					rlen_q <= cfg_rlen;
					wpos_q <= '0;
					fill_q <= '0;
				end
				REG_POSTROLL: postroll_q <= cfg_data;
				default: ;
			endcase
		end else begin
			case (state_q)
				ST_EXEC: begin
					rd_ok_q <= 1'b0;
					case (op_q)
						OP_SAMPLE: begin
							if (rlen_q != '0) begin
								wpos_q <= wpos_nxt;
								if (fill_q < rlen_q) begin
									fill_q <= fill_q + RFW'(1);
								end
							end
							if (active_q) begin
								count_q <= count_new;
								if (stop_on_sample) begin
									active_q <= 1'b0;
									commit_q <= 1'b0;
								end
							end
						end
						OP_BEGIN: begin
							count_q  <= '0;
							active_q <= 1'b1;
							commit_q <= 1'b0;
							target_q <= '0;
							rp_q     <= copy_start;
						end
						OP_COMMIT: begin
							if (active_q) begin
								if (postroll_q == '0) begin
									active_q <= 1'b0;
									commit_q <= 1'b0;
								end else begin
									commit_q <= 1'b1;
									target_q <= TW'(count_q) + TW'(postroll_q);
								end
							end
						end
						default: rd_ok_q <= rd_in_range;
					endcase
				end
				ST_COPY_RD: begin
					if (copy_more) begin
						rp_q <= rp_nxt;
					end
				end
				ST_COPY_WR: begin
					count_q <= count_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	ppac_ram #(
		.WIDTH (16),
		.DEPTH (RING_DEPTH)
	) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (wpos_q),
		.wdata (sample_q),
		.raddr (rp_q),
		.rdata (ring_rdata)
	);

	ppac_ram #(
		.WIDTH (16),
		.DEPTH (CAPTURE_DEPTH)
	) u_capture_ram (
		.clk   (clk),
		.we    (cap_we),
		.waddr (cap_waddr),
		.wdata (cap_wdata),
		.raddr (cap_raddr),
		.rdata (cap_rdata)
	);

	always_comb begin
		rsp.read_sample    = rd_ok_q ? cap_rdata : '0;
		rsp.read_valid     = rd_ok_q;
		rsp.capture_length = count_q[16:0];
		rsp.recording      = active_q;
		rsp.post_pending   = commit_q;
	end

endmodule

[rtl/ppac_checker.sv]
// Port-level checker for the audio capture block, with its bind
`include "preroll_postroll_audio_capture_top_defines.svh"

module ppac_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input ppac_pkg::ppac_rsp_t rsp
);

	import ppac_pkg::*;

	`PPAC_ASSERT_NXT(a_accept_busy, start && !busy, busy, "request accepted but block not busy")
	`PPAC_ASSERT_IMP(a_done_busy, done, busy, "result shown while block idle")
	`PPAC_ASSERT_NXT(a_done_single, done, !done, "result shown for more than one cycle")
	`PPAC_ASSERT_IMP(a_read_len, done && rsp.read_valid, rsp.capture_length != '0,
		"valid read from an empty capture")
	`PPAC_ASSERT_IMP(a_post_rec, done && rsp.post_pending, rsp.recording,
		"post-roll pending while not recording")

endmodule

bind preroll_postroll_audio_capture_top ppac_checker u_ppac_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
